// ===== rtl/core/mie_pkg.sv =====
package mie_pkg;

    // data memory geometry
    localparam int MEM_BYTES = 65536;
    localparam int MEM_WORDS = MEM_BYTES / 4;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_BADMEM  = 2'd2,
        ST_SYSCALL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } t_size;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // SPECIAL funct codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2a;
    localparam logic [5:0] FN_SLTU    = 6'h2b;

    localparam logic [31:0] PC_REGION_MASK = 32'hf000_0000;

    // everything one item decides in the execute stage
    typedef struct packed {
        t_status            status;
        logic [31:0]        npc;
        logic               wr;
        logic [4:0]         widx;
        logic [31:0]        wval;
        logic               is_load;
        t_size              ld_size;
        logic               ld_signed;
        logic [1:0]         ld_off;
        logic               mem_we;
        logic [3:0]         mem_be;
        logic [MEM_AW-1:0]  mem_addr;
        logic [31:0]        mem_wdata;
        logic               hilo_we;
        logic [31:0]        hi;
        logic [31:0]        lo;
    } t_exec_res;

endpackage

// ===== rtl/core/mie_regfile.sv =====
module mie_regfile (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_re,
    input  logic [4:0]  i_ra,
    input  logic [4:0]  i_rb,
    input  logic        i_we,
    input  logic [4:0]  i_wa,
    input  logic [31:0] i_wd,
    output logic [31:0] o_rd_a,
    output logic [31:0] o_rd_b
);

    logic [31:0] r_mem [32];
    logic [31:0] r_valid;
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;

    // valid bits stand in for the all-zero reset of the entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // registered reads, write-first on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && i_wa == i_ra) begin
                r_rd_a <= i_wd;
            end else begin
                r_rd_a <= r_valid[i_ra] ? r_mem[i_ra] : 32'd0;
            end
            if (i_we && i_wa == i_rb) begin
                r_rd_b <= i_wd;
            end else begin
                r_rd_b <= r_valid[i_rb] ? r_mem[i_rb] : 32'd0;
            end
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// ===== rtl/core/mie_dmem.sv =====
module mie_dmem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [3:0]                  i_be,
    input  logic [mie_pkg::MEM_AW-1:0]  i_waddr,
    input  logic [31:0]                 i_wdata,
    input  logic                        i_re,
    input  logic [mie_pkg::MEM_AW-1:0]  i_raddr,
    output logic [31:0]                 o_rdata
);

    // four byte lanes, little-endian within the word
    for (genvar g = 0; g < 4; g++) begin : g_lane
        logic [7:0] r_mem [mie_pkg::MEM_WORDS];
        logic [7:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (i_we && i_be[g]) begin
                r_mem[i_waddr] <= i_wdata[8*g +: 8];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_re) begin
                r_rd <= r_mem[i_raddr];
            end
        end

        assign o_rdata[8*g +: 8] = r_rd;
    end

endmodule

// ===== rtl/core/mie_exec.sv =====
module mie_exec (
    input  logic                 i_kind,
    input  logic [31:0]          i_instruction,
    input  logic [15:0]          i_preload_address,
    input  logic [31:0]          i_preload_data,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    input  logic [31:0]          i_pc,
    input  logic [31:0]          i_hi,
    input  logic [31:0]          i_lo,
    output mie_pkg::t_exec_res   o_res
);

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] imm;
    logic [31:0] simm;
    logic [31:0] ea;
    logic [31:0] pc4;
    logic [31:0] jtarget;
    logic [31:0] btarget;
    logic [31:0] pl_addr;
    logic        mul_signed;
    logic signed [65:0] prod;
    logic        ea_ok_b;
    logic        ea_ok_h;
    logic        ea_ok_w;

    assign op   = i_instruction[31:26];
    assign fn   = i_instruction[5:0];
    assign rt   = i_instruction[20:16];
    assign rd   = i_instruction[15:11];
    assign sh   = i_instruction[10:6];
    assign imm  = {16'd0, i_instruction[15:0]};
    assign simm = {{16{i_instruction[15]}}, i_instruction[15:0]};
    assign ea   = i_a + simm;
    assign pc4  = i_pc + 32'd4;
    assign jtarget = (pc4 & mie_pkg::PC_REGION_MASK) | {4'd0, i_instruction[25:0], 2'b00};
    assign btarget = pc4 + {simm[29:0], 2'b00};
    assign pl_addr = {16'd0, i_preload_address[15:2], 2'b00};

    // nonzero, inside memory, aligned to the access size
    assign ea_ok_b = (ea != 32'd0) && (ea < 32'(mie_pkg::MEM_BYTES));
    assign ea_ok_h = ea_ok_b && !ea[0];
    assign ea_ok_w = ea_ok_b && (ea[1:0] == 2'b00);

    // 33x33 multiply covers both signed and unsigned forms
    assign mul_signed = (fn == mie_pkg::FN_MULT);
    assign prod = $signed({mul_signed & i_a[31], i_a}) * $signed({mul_signed & i_b[31], i_b});

    always_comb begin
        o_res           = '0;
        o_res.status    = mie_pkg::ST_OK;
        o_res.npc       = pc4;
        o_res.ld_size   = mie_pkg::SZ_WORD;
        o_res.ld_off    = ea[1:0];
        o_res.mem_addr  = ea[mie_pkg::MEM_AW+1:2];
        o_res.hi        = prod[63:32];
        o_res.lo        = prod[31:0];

        if (i_kind) begin
            // host preload of one word
            o_res.npc = i_pc;
            if (pl_addr + 32'd4 > 32'(mie_pkg::MEM_BYTES)) begin
                o_res.status = mie_pkg::ST_BADMEM;
            end else begin
                o_res.mem_we    = 1'b1;
                o_res.mem_be    = 4'b1111;
                o_res.mem_addr  = pl_addr[mie_pkg::MEM_AW+1:2];
                o_res.mem_wdata = i_preload_data;
            end
        end else begin
            case (op)
                mie_pkg::OP_SPECIAL: begin
                    o_res.widx = rd;
                    case (fn)
                        mie_pkg::FN_SLL: begin
                            o_res.wr = 1'b1; o_res.wval = i_b << sh;
                        end
                        mie_pkg::FN_SRL: begin
                            o_res.wr = 1'b1; o_res.wval = i_b >> sh;
                        end
                        mie_pkg::FN_SRA: begin
                            o_res.wr = 1'b1; o_res.wval = $unsigned($signed(i_b) >>> sh);
                        end
                        mie_pkg::FN_JR: begin
                            o_res.npc = i_a;
                        end
                        mie_pkg::FN_JALR: begin
                            o_res.npc = i_a; o_res.wr = 1'b1; o_res.wval = pc4;
                        end
                        mie_pkg::FN_SYSCALL: begin
                            o_res.status = mie_pkg::ST_SYSCALL;
                        end
                        mie_pkg::FN_MFHI: begin
                            o_res.wr = 1'b1; o_res.wval = i_hi;
                        end
                        mie_pkg::FN_MFLO: begin
                            o_res.wr = 1'b1; o_res.wval = i_lo;
                        end
                        mie_pkg::FN_MULT, mie_pkg::FN_MULTU: begin
                            o_res.hilo_we = 1'b1;
                        end
                        mie_pkg::FN_ADDU: begin
                            o_res.wr = 1'b1; o_res.wval = i_a + i_b;
                        end
                        mie_pkg::FN_SUBU: begin
                            o_res.wr = 1'b1; o_res.wval = i_a - i_b;
                        end
                        mie_pkg::FN_AND: begin
                            o_res.wr = 1'b1; o_res.wval = i_a & i_b;
                        end
                        mie_pkg::FN_OR: begin
                            o_res.wr = 1'b1; o_res.wval = i_a | i_b;
                        end
                        mie_pkg::FN_XOR: begin
                            o_res.wr = 1'b1; o_res.wval = i_a ^ i_b;
                        end
                        mie_pkg::FN_NOR: begin
                            o_res.wr = 1'b1; o_res.wval = ~(i_a | i_b);
                        end
                        mie_pkg::FN_SLT: begin
                            o_res.wr = 1'b1;
                            o_res.wval = {31'd0, $signed(i_a) < $signed(i_b)};
                        end
                        mie_pkg::FN_SLTU: begin
                            o_res.wr = 1'b1; o_res.wval = {31'd0, i_a < i_b};
                        end
                        default: begin
                            o_res.status = mie_pkg::ST_ILLEGAL;
                        end
                    endcase
                end
                mie_pkg::OP_J: begin
                    o_res.npc = jtarget;
                end
                mie_pkg::OP_JAL: begin
                    o_res.npc = jtarget; o_res.wr = 1'b1;
                    o_res.widx = 5'd31; o_res.wval = pc4;
                end
                mie_pkg::OP_BEQ: begin
                    if (i_a == i_b) o_res.npc = btarget;
                end
                mie_pkg::OP_BNE: begin
                    if (i_a != i_b) o_res.npc = btarget;
                end
                mie_pkg::OP_ADDIU: begin
                    o_res.wr = 1'b1; o_res.widx = rt; o_res.wval = ea;
                end
                mie_pkg::OP_SLTI: begin
                    o_res.wr = 1'b1; o_res.widx = rt;
                    o_res.wval = {31'd0, $signed(i_a) < $signed(simm)};
                end
                mie_pkg::OP_SLTIU: begin
                    o_res.wr = 1'b1; o_res.widx = rt; o_res.wval = {31'd0, i_a < simm};
                end
                mie_pkg::OP_ANDI: begin
                    o_res.wr = 1'b1; o_res.widx = rt; o_res.wval = i_a & imm;
                end
                mie_pkg::OP_ORI: begin
                    o_res.wr = 1'b1; o_res.widx = rt; o_res.wval = i_a | imm;
                end
                mie_pkg::OP_XORI: begin
                    o_res.wr = 1'b1; o_res.widx = rt; o_res.wval = i_a ^ imm;
                end
                mie_pkg::OP_LUI: begin
                    o_res.wr = 1'b1; o_res.widx = rt; o_res.wval = {imm[15:0], 16'd0};
                end
                mie_pkg::OP_LB, mie_pkg::OP_LBU: begin
                    o_res.widx      = rt;
                    o_res.ld_size   = mie_pkg::SZ_BYTE;
                    o_res.ld_signed = (op == mie_pkg::OP_LB);
                    if (ea_ok_b) begin
                        o_res.wr = 1'b1; o_res.is_load = 1'b1;
                    end else begin
                        o_res.status = mie_pkg::ST_BADMEM;
                    end
                end
                mie_pkg::OP_LH, mie_pkg::OP_LHU: begin
                    o_res.widx      = rt;
                    o_res.ld_size   = mie_pkg::SZ_HALF;
                    o_res.ld_signed = (op == mie_pkg::OP_LH);
                    if (ea_ok_h) begin
                        o_res.wr = 1'b1; o_res.is_load = 1'b1;
                    end else begin
                        o_res.status = mie_pkg::ST_BADMEM;
                    end
                end
                mie_pkg::OP_LW: begin
                    o_res.widx = rt;
                    if (ea_ok_w) begin
                        o_res.wr = 1'b1; o_res.is_load = 1'b1;
                    end else begin
                        o_res.status = mie_pkg::ST_BADMEM;
                    end
                end
                mie_pkg::OP_SB: begin
                    o_res.mem_be    = 4'b0001 << ea[1:0];
                    o_res.mem_wdata = {4{i_b[7:0]}};
                    if (ea_ok_b) o_res.mem_we = 1'b1;
                    else         o_res.status = mie_pkg::ST_BADMEM;
                end
                mie_pkg::OP_SH: begin
                    o_res.mem_be    = ea[1] ? 4'b1100 : 4'b0011;
                    o_res.mem_wdata = {2{i_b[15:0]}};
                    if (ea_ok_h) o_res.mem_we = 1'b1;
                    else         o_res.status = mie_pkg::ST_BADMEM;
                end
                mie_pkg::OP_SW: begin
                    o_res.mem_be    = 4'b1111;
                    o_res.mem_wdata = i_b;
                    if (ea_ok_w) o_res.mem_we = 1'b1;
                    else         o_res.status = mie_pkg::ST_BADMEM;
                end
                default: begin
                    o_res.status = mie_pkg::ST_ILLEGAL;
                end
            endcase

            // a flagged item leaves all state alone
            if (o_res.status == mie_pkg::ST_ILLEGAL || o_res.status == mie_pkg::ST_BADMEM) begin
                o_res.npc     = i_pc;
                o_res.wr      = 1'b0;
                o_res.is_load = 1'b0;
                o_res.mem_we  = 1'b0;
                o_res.hilo_we = 1'b0;
            end
        end

        // register 0 is never written
        if (o_res.widx == 5'd0) begin
            o_res.wr      = 1'b0;
            o_res.is_load = 1'b0;
        end
        if (!o_res.wr) begin
            o_res.widx = 5'd0;
            o_res.wval = 32'd0;
        end
    end

endmodule

// ===== rtl/core/mips_instruction_execute.sv =====
// Channel | Valid       | Stall       | Payload
// in      | i_in_valid  | o_in_stall  | i_kind, i_instruction, i_preload_address, i_preload_data
// out     | o_out_valid | i_out_stall | o_status, o_next_pc, o_reg_written, o_reg_index,
//         |             |             | o_reg_value
//
// Each item is registered on acceptance together with its register-file read, then
// execute loads the result register. Loads read the data memory on the same edge that
// loads the result register. One item per cycle is sustained unless the output stalls or
// the clearing pass runs; results forward from the result stage, so no dependency stalls.
// After reset a clearing pass zeroes the data memory, one word a cycle: all 16384 words
// (MEM_BYTES/4), with o_in_stall high.
// A stalled result holds the pipeline once the execute stage is also full.
module mips_instruction_execute (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [31:0] i_instruction,
    input  logic [15:0] i_preload_address,
    input  logic [31:0] i_preload_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_next_pc,
    output logic        o_reg_written,
    output logic [4:0]  o_reg_index,
    output logic [31:0] o_reg_value
);

    localparam int AW = mie_pkg::MEM_AW;

    // clearing pass
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // execute stage input register
    logic        r_ex_v;
    logic        r_ex_kind;
    logic [31:0] r_ex_instr;
    logic [15:0] r_ex_paddr;
    logic [31:0] r_ex_pdata;

    // architectural registers
    logic [31:0] r_pc;
    logic [31:0] r_hi;
    logic [31:0] r_lo;

    // result register
    logic              r_res_v;
    logic              r_res_new;
    mie_pkg::t_status  r_res_status;
    logic [31:0]       r_res_npc;
    logic              r_res_wr;
    logic [4:0]        r_res_idx;
    logic [31:0]       r_res_wval;
    logic              r_res_is_load;
    mie_pkg::t_size    r_res_ld_size;
    logic              r_res_ld_signed;
    logic [1:0]        r_res_ld_off;

    logic        accept;
    logic        en1;
    logic        en2;
    logic        adv;
    logic [31:0] rf_a;
    logic [31:0] rf_b;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] mem_rdata;
    logic [31:0] ld_val;
    logic [31:0] s2_val;
    logic        mem_we;
    logic [3:0]  mem_be;
    logic [AW-1:0] mem_waddr;
    logic [31:0] mem_wdata;
    mie_pkg::t_exec_res res;

    // pipeline flow
    assign en2    = !r_res_v || !i_out_stall;
    assign en1    = !r_ex_v || en2;
    assign adv    = r_ex_v && en2;
    assign o_in_stall = !en1 || r_clr_busy;
    assign accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {AW{1'b1}}) r_clr_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_v <= 1'b0;
        end else if (accept) begin
            r_ex_v <= 1'b1;
        end else if (adv) begin
            r_ex_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ex_kind  <= i_kind;
            r_ex_instr <= i_instruction;
            r_ex_paddr <= i_preload_address;
            r_ex_pdata <= i_preload_data;
        end
    end

    mie_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (accept),
        .i_ra    (i_instruction[25:21]),
        .i_rb    (i_instruction[20:16]),
        .i_we    (r_res_new && r_res_wr),
        .i_wa    (r_res_idx),
        .i_wd    (s2_val),
        .o_rd_a  (rf_a),
        .o_rd_b  (rf_b)
    );

    // forward the result stage's write
    assign op_a = (r_res_v && r_res_wr && r_res_idx == r_ex_instr[25:21]) ? s2_val : rf_a;
    assign op_b = (r_res_v && r_res_wr && r_res_idx == r_ex_instr[20:16]) ? s2_val : rf_b;

    mie_exec u_exec (
        .i_kind            (r_ex_kind),
        .i_instruction     (r_ex_instr),
        .i_preload_address (r_ex_paddr),
        .i_preload_data    (r_ex_pdata),
        .i_a               (op_a),
        .i_b               (op_b),
        .i_pc              (r_pc),
        .i_hi              (r_hi),
        .i_lo              (r_lo),
        .o_res             (res)
    );

    // memory write port shared with the clearing pass
    assign mem_we    = r_clr_busy || (adv && res.mem_we);
    assign mem_be    = r_clr_busy ? 4'b1111 : res.mem_be;
    assign mem_waddr = r_clr_busy ? r_clr_addr : res.mem_addr;
    assign mem_wdata = r_clr_busy ? 32'd0 : res.mem_wdata;

    mie_dmem u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_be    (mem_be),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (adv && res.is_load),
        .i_raddr (res.mem_addr),
        .o_rdata (mem_rdata)
    );

    // architectural state commits as the item leaves execute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= 32'd0;
            r_hi <= 32'd0;
            r_lo <= 32'd0;
        end else if (adv) begin
            r_pc <= res.npc;
            if (res.hilo_we) begin
                r_hi <= res.hi;
                r_lo <= res.lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v   <= 1'b0;
            r_res_new <= 1'b0;
            r_res_wr  <= 1'b0;
        end else begin
            r_res_new <= adv;
            if (adv) begin
                r_res_v  <= 1'b1;
                r_res_wr <= res.wr;
            end else if (!i_out_stall) begin
                r_res_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res_status    <= res.status;
            r_res_npc       <= res.npc;
            r_res_idx       <= res.widx;
            r_res_wval      <= res.wval;
            r_res_is_load   <= res.is_load;
            r_res_ld_size   <= res.ld_size;
            r_res_ld_signed <= res.ld_signed;
            r_res_ld_off    <= res.ld_off;
        end
    end

    // load lane select and extension
    always_comb begin
        logic [7:0]  lb;
        logic [15:0] lh;
        lb = mem_rdata[8*r_res_ld_off +: 8];
        lh = r_res_ld_off[1] ? mem_rdata[31:16] : mem_rdata[15:0];
        case (r_res_ld_size)
            mie_pkg::SZ_BYTE: ld_val = {{24{r_res_ld_signed & lb[7]}}, lb};
            mie_pkg::SZ_HALF: ld_val = {{16{r_res_ld_signed & lh[15]}}, lh};
            default:          ld_val = mem_rdata;
        endcase
    end

    assign s2_val = r_res_is_load ? ld_val : r_res_wval;

    assign o_out_valid   = r_res_v;
    assign o_status      = r_res_status;
    assign o_next_pc     = r_res_npc;
    assign o_reg_written = r_res_wr;
    assign o_reg_index   = r_res_idx;
    assign o_reg_value   = s2_val;

endmodule

// ===== rtl/core/mie_checker.sv =====
module mie_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_next_pc,
    input logic        o_reg_written,
    input logic [4:0]  o_reg_index,
    input logic [31:0] o_reg_value
);

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_next_pc)
            && $stable(o_reg_value) && $stable(o_status))
        else $error("stalled result changed");

    // flagged items write no register
    a_flag_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == mie_pkg::ST_ILLEGAL || o_status == mie_pkg::ST_BADMEM)
            |-> !o_reg_written)
        else $error("flagged item wrote a register");

    // unused write fields are zero
    a_nowr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_reg_written |-> o_reg_index == 5'd0 && o_reg_value == 32'd0)
        else $error("write fields not zero");

    // register 0 never reported written
    a_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reg_written |-> o_reg_index != 5'd0)
        else $error("register 0 written");

endmodule

bind mips_instruction_execute mie_checker u_mie_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_next_pc     (o_next_pc),
    .o_reg_written (o_reg_written),
    .o_reg_index   (o_reg_index),
    .o_reg_value   (o_reg_value)
);
